FILE: sv/lrd_pkg.sv
// ----------------------------------------------------------------------------
// lrd_pkg: shared types and constants for the log record deframer
// Record framing codes, status codes, word types and the byte-wide CRC-32 step.
// ----------------------------------------------------------------------------
package lrd_pkg;

  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES      = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_LEN_RESET = 32'd1024 * 32'd1024;

  // parse phase codes
  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_CRC  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  // record status codes
  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_GOOD  = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_BIG   = 3'd3;
  localparam logic [2:0] ST_TRUNC = 3'd4;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       record_end;
    logic [2:0] record_status;
  } out_word_t;

  // reflected crc-32 over one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/log_record_deframer_crc32_top.sv
// ----------------------------------------------------------------------------
// log_record_deframer_crc32_top: length / crc-32 log record deframer
// Splits a log byte stream into records, checks each payload crc-32 and
// passes payload bytes out with an end-of-record status.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | fields
//  in      | input     | in_valid/in_stall  | stream_byte, end_of_stream
//  out     | output    | out_valid/out_stall| payload_valid, payload_byte,
//          |           |                    | record_end, record_status
//  cfg     | input     | cfg_wr_en          | max_record_length
//
//  one word in, one word out; an accepted word passes the input register, then the result register
//  sustained rate is one word per cycle while out_stall is low, set by the single crc byte step
//  input register feeds the parser, result register parts it from out_stall
//  out_stall backs up through the input register to in_stall in the same cycle
//  synchronous active-low reset clears parser state and restores the length limit
// ----------------------------------------------------------------------------
module log_record_deframer_crc32_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_record_end,
  output logic [2:0]  out_record_status
);

  logic               in_vld_r;
  lrd_pkg::in_word_t  in_word_r;
  logic               advance;
  logic               step;
  logic               in_accept;
  lrd_pkg::out_word_t res;
  lrd_pkg::out_word_t out_word;

  assign in_stall  = in_vld_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign step      = in_vld_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_accept) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_word_r.stream_byte   <= in_stream_byte;
      in_word_r.end_of_stream <= in_end_of_stream;
    end
  end

  lrd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (in_word_r),
    .res         (res)
  );

  lrd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_vld_r),
    .load_word  (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  assign out_payload_valid = out_word.payload_valid;
  assign out_payload_byte  = out_word.payload_byte;
  assign out_record_end    = out_word.record_end;
  assign out_record_status = out_word.record_status;

endmodule

FILE: sv/lrd_parse.sv
// ----------------------------------------------------------------------------
// lrd_parse: record header parser, payload crc and status
// Holds the framing state and the length limit; one step per word.
// ----------------------------------------------------------------------------
module lrd_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  logic              step,
  input  lrd_pkg::in_word_t item,
  output lrd_pkg::out_word_t res
);

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  hdr_idx_r, hdr_idx_nxt;
  logic [31:0] rec_len_r, rec_len_nxt;
  logic [31:0] crc_stored_r, crc_stored_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] max_len_r;
  logic [31:0] crc_step;
  logic [4:0]  sh;
  logic        hdr_last;

  assign sh       = {hdr_idx_r, 3'b000};
  assign hdr_last = (hdr_idx_r == 2'd3);
  assign crc_step = lrd_pkg::crc_byte(crc_r, item.stream_byte);

  always_comb begin
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    rec_len_nxt    = rec_len_r;
    crc_stored_nxt = crc_stored_r;
    remain_nxt     = remain_r;
    crc_nxt        = crc_r;
    res            = '0;
    case (phase_r)
      lrd_pkg::PH_LEN: begin
        rec_len_nxt[sh +: 8] = item.stream_byte;
        if (hdr_last) begin
          hdr_idx_nxt = 2'd0;
          phase_nxt   = lrd_pkg::PH_CRC;
        end else begin
          hdr_idx_nxt = hdr_idx_r + 2'd1;
        end
        if (item.end_of_stream) begin
          res.record_end    = 1'b1;
          res.record_status = lrd_pkg::ST_TRUNC;
        end
      end
      lrd_pkg::PH_CRC: begin
        crc_stored_nxt[sh +: 8] = item.stream_byte;
        if (hdr_last) begin
          hdr_idx_nxt = 2'd0;
          crc_nxt     = lrd_pkg::CRC_ONES;
          if (rec_len_r > max_len_r) begin
            res.record_end    = 1'b1;
            res.record_status = lrd_pkg::ST_BIG;
            phase_nxt         = lrd_pkg::PH_STOP;
          end else if (rec_len_r == 32'd0) begin
            // empty payload: crc of no data is zero
            res.record_end    = 1'b1;
            res.record_status = (crc_stored_nxt == 32'd0) ? lrd_pkg::ST_GOOD
                                                          : lrd_pkg::ST_BAD;
            phase_nxt         = lrd_pkg::PH_LEN;
            rec_len_nxt       = 32'd0;
          end else begin
            remain_nxt = rec_len_r;
            phase_nxt  = lrd_pkg::PH_PAY;
            if (item.end_of_stream) begin
              res.record_end    = 1'b1;
              res.record_status = lrd_pkg::ST_TRUNC;
            end
          end
        end else begin
          hdr_idx_nxt = hdr_idx_r + 2'd1;
          if (item.end_of_stream) begin
            res.record_end    = 1'b1;
            res.record_status = lrd_pkg::ST_TRUNC;
          end
        end
      end
      lrd_pkg::PH_PAY: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = item.stream_byte;
        crc_nxt           = crc_step;
        remain_nxt        = remain_r - 32'd1;
        if (remain_r == 32'd1) begin
          res.record_end    = 1'b1;
          res.record_status = ((crc_step ^ lrd_pkg::CRC_ONES) == crc_stored_r)
                              ? lrd_pkg::ST_GOOD : lrd_pkg::ST_BAD;
          phase_nxt         = lrd_pkg::PH_LEN;
          rec_len_nxt       = 32'd0;
          crc_nxt           = lrd_pkg::CRC_ONES;
        end else if (item.end_of_stream) begin
          res.record_end    = 1'b1;
          res.record_status = lrd_pkg::ST_TRUNC;
        end
      end
      default: begin
        // stopped: words ignored until end of stream
      end
    endcase
    if (item.end_of_stream) begin
      phase_nxt      = lrd_pkg::PH_LEN;
      hdr_idx_nxt    = 2'd0;
      rec_len_nxt    = 32'd0;
      crc_stored_nxt = 32'd0;
      remain_nxt     = 32'd0;
      crc_nxt        = lrd_pkg::CRC_ONES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lrd_pkg::PH_LEN;
      hdr_idx_r    <= 2'd0;
      rec_len_r    <= 32'd0;
      crc_stored_r <= 32'd0;
      remain_r     <= 32'd0;
      crc_r        <= lrd_pkg::CRC_ONES;
    end else if (step) begin
      phase_r      <= phase_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      rec_len_r    <= rec_len_nxt;
      crc_stored_r <= crc_stored_nxt;
      remain_r     <= remain_nxt;
      crc_r        <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= lrd_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

`ifndef SYNTH
  a_status_iff_end: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> (res.record_end == (res.record_status != lrd_pkg::ST_NONE)))
    else $error("record_end and record_status disagree");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.end_of_stream) |=>
      (phase_r == lrd_pkg::PH_LEN && hdr_idx_r == 2'd0 && crc_r == lrd_pkg::CRC_ONES))
    else $error("state not cleared after end of stream");

  a_last_byte_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == lrd_pkg::PH_PAY && remain_r == 32'd1) |=>
      (phase_r == lrd_pkg::PH_LEN && rec_len_r == 32'd0))
    else $error("record not closed on last payload byte");

  a_pay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lrd_pkg::PH_PAY) |-> (remain_r != 32'd0))
    else $error("payload phase with nothing remaining");

  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == lrd_pkg::PH_STOP) |-> (res == '0))
    else $error("stopped parser produced a result");
`endif

endmodule

FILE: sv/lrd_out_reg.sv
// ----------------------------------------------------------------------------
// lrd_out_reg: result register
// Holds one result word for the downstream side and frees when it is taken.
// ----------------------------------------------------------------------------
module lrd_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load_valid,
  input  lrd_pkg::out_word_t load_word,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_stall,
  output lrd_pkg::out_word_t out_word
);

  logic               vld_r;
  lrd_pkg::out_word_t word_r;

  // register may take a new word when empty or being drained
  assign advance   = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      word_r <= load_word;
    end
  end

endmodule

FILE: sim/tb_log_record_deframer_crc32_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_log_record_deframer_crc32_top: self-checking bench for the record deframer
// Feeds log byte streams of framed records (good, corrupted, empty, oversize and
// cut short), predicts every result word and checks each one as it leaves, over
// several length limits, with random gaps on both channels in four of six phases.
// ----------------------------------------------------------------------------
module tb_log_record_deframer_crc32_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BYTES_PER_PHASE = 120;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_stream_byte = 8'd0;
  logic        in_end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_payload_valid;
  logic [7:0]  out_payload_byte;
  logic        out_record_end;
  logic [2:0]  out_record_status;

  log_record_deframer_crc32_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_stream_byte    (in_stream_byte),
    .in_end_of_stream  (in_end_of_stream),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_valid (out_payload_valid),
    .out_payload_byte  (out_payload_byte),
    .out_record_end    (out_record_end),
    .out_record_status (out_record_status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  lrd_pkg::in_word_t  log_bytes_q[$];
  lrd_pkg::out_word_t deframed_q[$];
  int        bytes_queued = 0;
  int        words_checked = 0;
  int        send_idle_pct = 37;
  int        stall_pct = 49;
  int        cycle_count = 0;
  bit        failed = 1'b0;

  // predicted parser state
  logic [1:0]  parse_ph = lrd_pkg::PH_LEN;
  logic [1:0]  hdr_pos = 2'd0;
  logic [31:0] rec_len = 32'd0;
  logic [31:0] hdr_crc = 32'd0;
  logic [31:0] bytes_left = 32'd0;
  logic [31:0] crc_acc = lrd_pkg::CRC_ONES;
  logic [31:0] len_limit = lrd_pkg::MAX_LEN_RESET;

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ d[k];
      r = (r >> 1) ^ (fb ? lrd_pkg::CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  task automatic deframe_byte(input logic [7:0] b, input logic eos,
                              output lrd_pkg::out_word_t res);
    res = '0;
    case (parse_ph)
      lrd_pkg::PH_LEN: begin
        rec_len[hdr_pos*8 +: 8] = b;
        if (hdr_pos == 2'd3) begin
          hdr_pos = 2'd0;
          parse_ph = lrd_pkg::PH_CRC;
        end else begin
          hdr_pos = hdr_pos + 2'd1;
        end
        if (eos) begin
          res.record_end = 1'b1;
          res.record_status = lrd_pkg::ST_TRUNC;
        end
      end
      lrd_pkg::PH_CRC: begin
        hdr_crc[hdr_pos*8 +: 8] = b;
        if (hdr_pos == 2'd3) begin
          hdr_pos = 2'd0;
          crc_acc = lrd_pkg::CRC_ONES;
          // limit check wins over everything else once the header is in
          if (rec_len > len_limit) begin
            res.record_end = 1'b1;
            res.record_status = lrd_pkg::ST_BIG;
            parse_ph = lrd_pkg::PH_STOP;
          end else if (rec_len == 32'd0) begin
            res.record_end = 1'b1;
            res.record_status = (hdr_crc == 32'd0) ? lrd_pkg::ST_GOOD : lrd_pkg::ST_BAD;
            parse_ph = lrd_pkg::PH_LEN;
            rec_len = 32'd0;
          end else begin
            bytes_left = rec_len;
            parse_ph = lrd_pkg::PH_PAY;
            if (eos) begin
              res.record_end = 1'b1;
              res.record_status = lrd_pkg::ST_TRUNC;
            end
          end
        end else begin
          hdr_pos = hdr_pos + 2'd1;
          if (eos) begin
            res.record_end = 1'b1;
            res.record_status = lrd_pkg::ST_TRUNC;
          end
        end
      end
      lrd_pkg::PH_PAY: begin
        res.payload_valid = 1'b1;
        res.payload_byte = b;
        crc_acc = crc32_step(crc_acc, b);
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) begin
          res.record_end = 1'b1;
          res.record_status = ((crc_acc ^ lrd_pkg::CRC_ONES) == hdr_crc)
                              ? lrd_pkg::ST_GOOD : lrd_pkg::ST_BAD;
          parse_ph = lrd_pkg::PH_LEN;
          rec_len = 32'd0;
          crc_acc = lrd_pkg::CRC_ONES;
        end else if (eos) begin
          res.record_end = 1'b1;
          res.record_status = lrd_pkg::ST_TRUNC;
        end
      end
      default: ;
    endcase
    if (eos) begin
      parse_ph = lrd_pkg::PH_LEN;
      hdr_pos = 2'd0;
      rec_len = 32'd0;
      hdr_crc = 32'd0;
      bytes_left = 32'd0;
      crc_acc = lrd_pkg::CRC_ONES;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eos);
    lrd_pkg::in_word_t w;
    w.stream_byte = b;
    w.end_of_stream = eos;
    log_bytes_q.insert(log_bytes_q.size(), w);
    bytes_queued++;
  endtask

  initial begin : stimulus_proc
    logic [31:0] limits [0:5];
    int          issued;
    limits[0] = lrd_pkg::MAX_LEN_RESET;
    limits[1] = 32'hFFFF_FFFF;
    limits[2] = 32'd0;
    limits[3] = 32'd16;
    limits[4] = lrd_pkg::MAX_LEN_RESET;
    limits[5] = 32'd3;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 37;
          stall_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          stall_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      if (ph != 0) begin
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= limits[ph];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        len_limit = limits[ph];
      end else begin
        // empty record with a zero crc, ending the stream
        repeat (7) queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b1);
        // stream cut in the length header
        queue_byte(8'hFF, 1'b1);
        // oversize length, then a byte in the stopped state
        repeat (4) queue_byte(8'hFF, 1'b0);
        repeat (4) queue_byte(8'h00, 1'b0);
        queue_byte(8'h55, 1'b1);
        // payload cut short by the end of the stream
        queue_byte(8'h03, 1'b0);
        repeat (3) queue_byte(8'h00, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7F, 1'b1);
      end
      issued = 0;
      while (issued < RANDOM_BYTES_PER_PHASE) queue_record_stream(len_limit, issued);
      while (words_checked < bytes_queued) @(posedge clk);
      repeat (4) @(posedge clk);
    end
    if (!failed) begin
      $display("log_record_deframer_crc32_top test passed");
    end else begin
      $display("log_record_deframer_crc32_top test failed");
    end
    $finish;
  end

  // stream builder used by the random part
  task automatic queue_record_stream(input logic [31:0] lim, inout int total);
    logic [7:0]  seq[$];
    logic [7:0]  b;
    logic [63:0] hdr;
    logic [31:0] len;
    logic [31:0] crc;
    logic [7:0]  pay[$];
    int          n_rec;
    int          kind;
    int          n_pay;
    int          rs;
    int          cut;
    bit          stop;
    n_rec = $urandom_range(4, 1);
    stop = 1'b0;
    for (int r = 0; r < n_rec && !stop; r++) begin
      kind = $urandom_range(99);
      rs = seq.size();
      pay.delete();
      if (kind < 8 && lim != 32'hFFFF_FFFF) begin
        len = lim + 32'd1 + (($urandom_range(1) == 0) ? 32'd0 : $urandom);
        if (len <= lim) len = 32'hFFFF_FFFF;
        hdr = {$urandom, len};
        for (int k = 0; k < 8; k++) seq.insert(seq.size(), hdr[8*k +: 8]);
        // trailing bytes land in the stopped state
        repeat ($urandom_range(5)) seq.insert(seq.size(), 8'($urandom));
        stop = 1'b1;
      end else begin
        if (kind < 18) len = ($urandom_range(3) == 0) ? $urandom : $urandom_range(30, 1);
        else if (kind < 23 && lim <= 32'd64) len = lim;
        else if (kind < 68) len = $urandom_range(8);
        else len = $urandom_range(48, 9);
        n_pay = (len > 32'd48) ? 48 : int'(len);
        crc = lrd_pkg::CRC_ONES;
        for (int i = 0; i < n_pay; i++) begin
          b = 8'($urandom);
          pay.insert(pay.size(), b);
          crc = crc32_step(crc, b);
        end
        crc = crc ^ lrd_pkg::CRC_ONES;
        if ($urandom_range(4) == 0) crc = crc ^ (32'd1 << $urandom_range(31));
        hdr = {crc, len};
        for (int k = 0; k < 8; k++) seq.insert(seq.size(), hdr[8*k +: 8]);
        for (int i = 0; i < n_pay; i++) seq.insert(seq.size(), pay[i]);
        // cut somewhere inside this record, possibly on its last byte
        if (kind < 18) begin
          cut = $urandom_range(seq.size() - 1, rs);
          while (seq.size() > cut + 1) void'(seq.pop_back());
          stop = 1'b1;
        end
      end
    end
    for (int i = 0; i < seq.size(); i++) queue_byte(seq[i], i == seq.size() - 1);
    total += seq.size();
  endtask

  // sender: holds a stalled word, otherwise loads the next one or idles
  always @(posedge clk) begin : drive_proc
    lrd_pkg::in_word_t  w;
    lrd_pkg::out_word_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_stream_byte <= 8'd0;
      in_end_of_stream <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_stream_byte, in_end_of_stream, res);
        deframed_q.insert(deframed_q.size(), res);
      end
      if (!in_valid || !in_stall) begin
        if (log_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = log_bytes_q.pop_front();
          in_valid <= 1'b1;
          in_stream_byte <= w.stream_byte;
          in_end_of_stream <= w.end_of_stream;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string fname, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  // receiver: checks each word leaving the block against the oldest prediction
  always @(posedge clk) begin : monitor_proc
    lrd_pkg::out_word_t exp_w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (deframed_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, %s%0d byte=%0d end=%0d status=%0d",
                   $time, "got valid=", out_payload_valid, out_payload_byte,
                   out_record_end, out_record_status);
          failed = 1'b1;
        end else begin
          exp_w = deframed_q.pop_front();
          words_checked++;
          check_field("payload_valid", exp_w.payload_valid, out_payload_valid);
          check_field("payload_byte", exp_w.payload_byte, out_payload_byte);
          check_field("record_end", exp_w.record_end, out_record_end);
          check_field("record_status", exp_w.record_status, out_record_status);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("log_record_deframer_crc32_top test failed");
      $finish;
    end
  end

endmodule
